// File: rtl/lcl_pkg.sv
// ----------------------------------------------------------------------------
// lcl_pkg
// Shared types and constants of the line/column locator: item and result
// structs, mode codes, controller commands and datapath status.
// ----------------------------------------------------------------------------
package lcl_pkg;

  localparam int MAX_LINES_DEF   = 1024;
  localparam int OFFSET_BITS_DEF = 24;

  localparam int LINE_W = 10;
  localparam int COL_W  = 24;
  localparam int QOFS_W = 24;

  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;

  localparam logic [1:0] MODE_BYTE  = 2'd0;
  localparam logic [1:0] MODE_CLOSE = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  typedef struct packed {
    logic [1:0]        mode;
    logic [7:0]        source_byte;
    logic [QOFS_W-1:0] query_offset;
    logic              null_query;
  } lcl_in_t;

  typedef struct packed {
    logic [LINE_W-1:0] line_index;
    logic [COL_W-1:0]  column_index;
    logic [QOFS_W-1:0] echoed_offset;
    logic              query_error;
  } lcl_out_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_BYTE,
    CMD_CLOSE,
    CMD_QUICK,
    CMD_SEARCH_INIT,
    CMD_SEARCH_STEP,
    CMD_FINISH
  } lcl_cmd_t;

  typedef struct packed {
    logic query_bad;
    logic search_more;
  } lcl_stat_t;

endpackage

// File: rtl/line_column_locator.sv
// ----------------------------------------------------------------------------
// line_column_locator
// Records newline offsets of a streamed source and maps byte offsets to
// 0-based line and column numbers by bisecting the newline table.
// ----------------------------------------------------------------------------
// A source byte or an end-of-source item does not raise busy, so bytes stream
// in back to back. A null query or a rejected query is answered without a
// search, and its result strobes on done in the next cycle. A searched query
// starts the first table read in its transfer cycle, then keeps busy high
// through the bisection steps (at most ceil(log2(entries + 1)), eleven for a
// full 1024-entry table) and a final step that forms the column; the result
// strobes on done in the cycle after that final step. The single read port
// of the newline table sets the pace: one entry is read per step. The result
// is shown for exactly one cycle on done and the receiver cannot stall it.
// No clearing pass runs after reset.
// ----------------------------------------------------------------------------
module line_column_locator
  import lcl_pkg::*;
#(
  parameter int MAX_LINES   = MAX_LINES_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  lcl_in_t  item,
  output logic     done,
  output lcl_out_t result
);

  lcl_cmd_t  cmd;
  lcl_stat_t stat;

  lcl_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .item (item),
    .stat (stat),
    .cmd  (cmd),
    .busy (busy)
  );

  lcl_datapath #(
    .MAX_LINES  (MAX_LINES),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_datapath (
    .clk   (clk),
    .rst   (rst),
    .item  (item),
    .cmd   (cmd),
    .stat  (stat),
    .result(result),
    .done  (done)
  );

endmodule

// File: rtl/lcl_ram.sv
// ----------------------------------------------------------------------------
// lcl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lcl_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/lcl_ctrl.sv
// ----------------------------------------------------------------------------
// lcl_ctrl
// Controller of the locator: decodes each accepted item and sequences the
// bisection search and the final column computation.
// ----------------------------------------------------------------------------
module lcl_ctrl
  import lcl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  lcl_in_t   item,
  input  lcl_stat_t stat,
  output lcl_cmd_t  cmd,
  output logic      busy
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = CMD_NONE;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          priority if (item.mode == MODE_BYTE) begin
            cmd = CMD_BYTE;
          end else if (item.mode == MODE_CLOSE) begin
            cmd = CMD_CLOSE;
          end else if (item.mode == MODE_QUERY) begin
            if (item.null_query || stat.query_bad) begin
              cmd = CMD_QUICK;
            end else begin
              cmd        = CMD_SEARCH_INIT;
              state_next = ST_SEARCH;
            end
          end else begin
            cmd = CMD_NONE;
          end
        end
      end
      ST_SEARCH: begin
        cmd = CMD_SEARCH_STEP;
        if (!stat.search_more) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd        = CMD_FINISH;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

// File: rtl/lcl_datapath.sv
// ----------------------------------------------------------------------------
// lcl_datapath
// Source bookkeeping, newline table, bisection registers and result register.
// ----------------------------------------------------------------------------
module lcl_datapath
  import lcl_pkg::*;
#(
  parameter int MAX_LINES   = MAX_LINES_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  lcl_in_t   item,
  input  lcl_cmd_t  cmd,
  output lcl_stat_t stat,
  output lcl_out_t  result,
  output logic      done
);

  localparam int OW = OFFSET_BITS;
  localparam int AW = $clog2(MAX_LINES);
  localparam int CW = $clog2(MAX_LINES + 1);
  localparam int XW = (OW > QOFS_W) ? OW : QOFS_W;
  localparam logic [OW-1:0] POS_MAX = {OW{1'b1}};

  // source state
  logic [CW-1:0] count;
  logic [OW-1:0] pos;
  logic [OW-1:0] length;
  logic          ovf;
  logic          closed;

  logic [CW-1:0] count_next;
  logic [OW-1:0] pos_next;
  logic [OW-1:0] length_next;
  logic          ovf_next;
  logic          closed_next;

  // search state
  logic [CW-1:0]     lo;
  logic [CW-1:0]     hi;
  logic [CW-1:0]     mid;
  logic [CW-1:0]     idx;
  logic [QOFS_W-1:0] q;

  logic [CW-1:0] lo_next;
  logic [CW-1:0] hi_next;
  logic [CW-1:0] mid_next;

  // table ports
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [OW-1:0] wr_data;
  logic [AW-1:0] rd_addr;
  logic [OW-1:0] rd_data;

  // helpers
  logic [CW-1:0] cnt_eff;
  logic [OW-1:0] pos_eff;
  logic          ovf_eff;
  logic          is_nl;
  logic          nl_fits;
  logic [XW-1:0] q_in_ext;
  logic [XW-1:0] q_ext;
  logic [XW-1:0] len_ext;
  logic [XW-1:0] rd_ext;
  logic [XW:0]   line_start;
  logic [XW:0]   col_full;
  logic          step_right;

  lcl_out_t result_next;
  logic     done_next;

  lcl_ram #(
    .WIDTH(OW),
    .DEPTH(MAX_LINES)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_comb begin
    // a byte after end of source opens a new source
    cnt_eff = closed ? '0 : count;
    pos_eff = closed ? '0 : pos;
    ovf_eff = closed ? 1'b0 : ovf;
    is_nl   = (item.source_byte == NEWLINE_CHAR);
    nl_fits = (cnt_eff < CW'(MAX_LINES - 1));

    q_in_ext = XW'(item.query_offset);
    q_ext    = XW'(q);
    len_ext  = XW'(length);
    rd_ext   = XW'(rd_data);

    stat.query_bad = !closed || ovf || (q_in_ext >= len_ext);

    // one bisection step on the entry read last cycle
    step_right = !(rd_ext > q_ext);
    lo_next    = step_right ? (mid + CW'(1)) : lo;
    hi_next    = step_right ? hi : mid;
    mid_next   = lo_next + ((hi_next - lo_next) >> 1);
    stat.search_more = (lo_next < hi_next);

    line_start = (idx == '0) ? '0 : ({1'b0, rd_ext} + (XW + 1)'(1));
    col_full   = ({1'b0, q_ext} >= line_start) ? ({1'b0, q_ext} - line_start) : '0;

    count_next  = count;
    pos_next    = pos;
    length_next = length;
    ovf_next    = ovf;
    closed_next = closed;
    wr_en       = 1'b0;
    wr_addr     = cnt_eff[AW-1:0];
    wr_data     = pos_eff;
    rd_addr     = mid[AW-1:0];
    result_next = result;
    done_next   = 1'b0;

    unique case (cmd)
      CMD_NONE: begin
      end
      CMD_BYTE: begin
        wr_en       = is_nl && nl_fits;
        count_next  = cnt_eff + CW'(wr_en);
        ovf_next    = ovf_eff || (is_nl && !nl_fits) || (pos_eff == POS_MAX);
        pos_next    = (pos_eff == POS_MAX) ? pos_eff : (pos_eff + OW'(1));
        length_next = closed ? '0 : length;
        closed_next = 1'b0;
      end
      CMD_CLOSE: begin
        if (!closed) begin
          wr_en       = (count < CW'(MAX_LINES));
          count_next  = count + CW'(wr_en);
          ovf_next    = ovf || !wr_en;
          length_next = pos;
          closed_next = 1'b1;
        end
      end
      CMD_QUICK: begin
        result_next.line_index    = '0;
        result_next.column_index  = '0;
        result_next.echoed_offset = item.null_query ? '0 : item.query_offset;
        result_next.query_error   = !item.null_query;
        done_next                 = 1'b1;
      end
      CMD_SEARCH_INIT: begin
        rd_addr = AW'(count >> 1);
      end
      CMD_SEARCH_STEP: begin
        // on the last step fetch the entry before the found one
        rd_addr = stat.search_more ? mid_next[AW-1:0] : AW'(lo_next - CW'(1));
      end
      CMD_FINISH: begin
        result_next.line_index    = LINE_W'(idx);
        result_next.column_index  = COL_W'(col_full);
        result_next.echoed_offset = q;
        result_next.query_error   = 1'b0;
        done_next                 = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      pos    <= '0;
      length <= '0;
      ovf    <= 1'b0;
      closed <= 1'b0;
      done   <= 1'b0;
    end else begin
      count  <= count_next;
      pos    <= pos_next;
      length <= length_next;
      ovf    <= ovf_next;
      closed <= closed_next;
      done   <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    if (cmd == CMD_SEARCH_INIT) begin
      q   <= item.query_offset;
      lo  <= '0;
      hi  <= count;
      mid <= count >> 1;
    end else if (cmd == CMD_SEARCH_STEP) begin
      lo  <= lo_next;
      hi  <= hi_next;
      mid <= mid_next;
      idx <= lo_next;
    end
  end

endmodule
